FILE: hw/rtl/bankers_safe_allocation_assert.svh
// Assertion macros for the banker's allocator.
// Relies on clk_i and rst_ni being in scope where a macro is used.
`ifndef BANKERS_SAFE_ALLOCATION_ASSERT_SVH
`define BANKERS_SAFE_ALLOCATION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bsa_pkg.sv
// Shared constants for the banker's allocator: field widths, command and status codes.
// No dependencies.
package bsa_pkg;

  localparam int unsigned MaxProcessesDef = 8;
  localparam int unsigned MaxResourcesDef = 4;
  localparam int unsigned CountWidthDef   = 16;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned ProcW    = 3;
  localparam int unsigned ResW     = 2;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned ActProcW = 4;
  localparam int unsigned ActResW  = 3;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CmdW-1:0] CMD_LOAD     = 3'd0;
  localparam logic [CmdW-1:0] CMD_TOTAL    = 3'd1;
  localparam logic [CmdW-1:0] CMD_REQUEST  = 3'd2;
  localparam logic [CmdW-1:0] CMD_FREE     = 3'd3;
  localparam logic [CmdW-1:0] CMD_FREE_ALL = 3'd4;
  localparam logic [CmdW-1:0] CMD_QUERY    = 3'd5;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_RES = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_PRC = 3'd2;
  localparam logic [StatusW-1:0] ST_EXCEEDS = 3'd3;
  localparam logic [StatusW-1:0] ST_UNSAFE  = 3'd4;
  localparam logic [StatusW-1:0] ST_UNAVAIL = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_ACT_PROC = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ACT_RES  = 1'b1;

endpackage

FILE: hw/rtl/bsa_ram.sv
// Generic single-port RAM with registered read (read-before-write).
// No dependencies.
module bsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bankers_safe_allocation.sv
// Banker's algorithm allocator: claim/allocation tables, available counts, safety walk.
// Depends on bsa_pkg, bsa_ram and bankers_safe_allocation_assert.svh.
//
// Channel   Direction  Handshake                      Payload
// command   in         start_i & !busy_o              command, process, resource, count, held
// result    out        result_valid_o (one cycle)     status, sequence_process, last
// config    in         cfg_valid_i & cfg_ready_o      cfg_index_i, cfg_data_i
//
// After reset both tables are zeroed, one cell a cycle, with busy_o high. load_entry and
// index rejects are answered straight from idle; free, set_total and free_all read the RAM
// before they write or answer. The safety walk uses one RAM port and one compare/add unit,
// at most np passes of np rows; a safe query then gives one result a cycle, np results in all.
// The result port has no back-pressure; config is always ready.
`include "bankers_safe_allocation_assert.svh"

module bankers_safe_allocation import bsa_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = MaxProcessesDef,
  parameter int unsigned MAX_RESOURCES = MaxResourcesDef,
  parameter int unsigned COUNT_WIDTH   = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [CmdW-1:0]     command_i,
  input  logic [ProcW-1:0]    process_i,
  input  logic [ResW-1:0]     resource_i,
  input  logic [FieldW-1:0]   count_i,
  input  logic [FieldW-1:0]   held_i,
  output logic                result_valid_o,
  output logic [StatusW-1:0]  status_o,
  output logic [ProcW-1:0]    sequence_process_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PW    = $clog2(MAX_PROCESSES);
  localparam int unsigned RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int unsigned PCW   = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned RCW   = $clog2(MAX_RESOURCES + 1);
  localparam int unsigned AW    = PW + RW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned CW    = COUNT_WIDTH;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_EXEC   = 4'd3;
  localparam logic [3:0] S_COL    = 4'd4;
  localparam logic [3:0] S_COLACC = 4'd5;
  localparam logic [3:0] S_FA     = 4'd6;
  localparam logic [3:0] S_FAACC  = 4'd7;
  localparam logic [3:0] S_WSEL   = 4'd8;
  localparam logic [3:0] S_WRD    = 4'd9;
  localparam logic [3:0] S_WCHK   = 4'd10;
  localparam logic [3:0] S_WADDRD = 4'd11;
  localparam logic [3:0] S_WACC   = 4'd12;
  localparam logic [3:0] S_WEND   = 4'd13;
  localparam logic [3:0] S_SEQ    = 4'd14;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? '1 : s[CW-1:0];
  endfunction

  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [ActProcW-1:0] act_proc_q;
  logic [ActResW-1:0]  act_res_q;
  logic [CmdW-1:0]     cmd_q, cmd_d;
  logic [PW-1:0]       p_q, p_d;
  logic [RW-1:0]       r_q, r_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       acc_q, acc_d;
  logic [CW-1:0]       old_q, old_d;
  logic [PCW-1:0]      wp_q, wp_d;
  logic [RW-1:0]       wr_q, wr_d;
  logic [PCW-1:0]      done_q, done_d;
  logic                prog_q, prog_d;
  logic [MAX_PROCESSES-1:0] fin_q, fin_d;
  logic [CW-1:0]       avail_q [MAX_RESOURCES];
  logic [CW-1:0]       avail_d [MAX_RESOURCES];
  logic [CW-1:0]       work_q  [MAX_RESOURCES];
  logic [CW-1:0]       work_d  [MAX_RESOURCES];
  logic [PW-1:0]       order_q [MAX_PROCESSES];
  logic [PW-1:0]       order_d [MAX_PROCESSES];
  logic                rvalid_q, rvalid_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [ProcW-1:0]    seqp_q, seqp_d;
  logic                last_q, last_d;

  logic [PCW-1:0] np_c, np_last;
  logic [RCW-1:0] nr_c;
  logic [RW-1:0]  nr_last;
  logic           accept;
  logic           p_in_bad, r_in_bad;
  logic [AW-1:0]  ram_addr;
  logic           claim_we, alloc_we;
  logic [CW-1:0]  claim_wdata, alloc_wdata, claim_rd, alloc_rd;
  logic [CW-1:0]  need_c, sum_c, amt_c;
  logic [CW:0]    claim_chk;

  // Register values out of range act as the nearest legal value.
  always_comb begin
    if (act_proc_q == '0) begin
      np_c = PCW'(1);
    end else if (32'(act_proc_q) > MAX_PROCESSES) begin
      np_c = PCW'(MAX_PROCESSES);
    end else begin
      np_c = PCW'(act_proc_q);
    end
    if (act_res_q == '0) begin
      nr_c = RCW'(1);
    end else if (32'(act_res_q) > MAX_RESOURCES) begin
      nr_c = RCW'(MAX_RESOURCES);
    end else begin
      nr_c = RCW'(act_res_q);
    end
  end

  assign np_last  = np_c - PCW'(1);
  assign nr_last  = RW'(nr_c - RCW'(1));
  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign p_in_bad = (32'(process_i) >= 32'(np_c));
  assign r_in_bad = (32'(resource_i) >= 32'(nr_c));

  assign need_c    = (alloc_rd >= claim_rd) ? '0 : claim_rd - alloc_rd;
  assign sum_c     = sat_add(acc_q, alloc_rd);
  assign amt_c     = (cnt_q < alloc_rd) ? cnt_q : alloc_rd;
  assign claim_chk = {1'b0, cnt_q} + {1'b0, alloc_rd};

  bsa_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_claim_ram (
    .clk_i   (clk_i),
    .we_i    (claim_we),
    .addr_i  (ram_addr),
    .wdata_i (claim_wdata),
    .rdata_o (claim_rd)
  );

  bsa_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (alloc_we),
    .addr_i  (ram_addr),
    .wdata_i (alloc_wdata),
    .rdata_o (alloc_rd)
  );

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cmd_d    = cmd_q;
    p_d      = p_q;
    r_d      = r_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    old_d    = old_q;
    wp_d     = wp_q;
    wr_d     = wr_q;
    done_d   = done_q;
    prog_d   = prog_q;
    fin_d    = fin_q;
    avail_d  = avail_q;
    work_d   = work_q;
    order_d  = order_q;
    rvalid_d = 1'b0;
    status_d = status_q;
    seqp_d   = seqp_q;
    last_d   = last_q;

    ram_addr    = {p_q, r_q};
    claim_we    = 1'b0;
    alloc_we    = 1'b0;
    claim_wdata = cnt_q;
    alloc_wdata = '0;

    case (state_q)
      S_CLR: begin
        ram_addr    = clr_q;
        claim_we    = 1'b1;
        alloc_we    = 1'b1;
        claim_wdata = '0;
        clr_d       = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        ram_addr = {PW'(process_i), RW'(resource_i)};
        if (accept) begin
          cmd_d  = command_i;
          p_d    = PW'(process_i);
          r_d    = RW'(resource_i);
          cnt_d  = CW'(count_i);
          case (command_i)
            CMD_QUERY: begin
              work_d  = avail_q;
              fin_d   = '0;
              done_d  = '0;
              prog_d  = 1'b0;
              wp_d    = '0;
              state_d = S_WSEL;
            end
            CMD_TOTAL: begin
              if (r_in_bad) begin
                rvalid_d = 1'b1; status_d = ST_BAD_RES; seqp_d = '0; last_d = 1'b1;
              end else begin
                acc_d   = '0;
                wp_d    = '0;
                state_d = S_COL;
              end
            end
            CMD_LOAD, CMD_REQUEST, CMD_FREE, CMD_FREE_ALL: begin
              if (p_in_bad) begin
                rvalid_d = 1'b1; status_d = ST_BAD_PRC; seqp_d = '0; last_d = 1'b1;
              end else if (command_i == CMD_FREE_ALL) begin
                wr_d    = '0;
                state_d = S_FA;
              end else if (r_in_bad) begin
                rvalid_d = 1'b1; status_d = ST_BAD_RES; seqp_d = '0; last_d = 1'b1;
              end else if (command_i == CMD_LOAD) begin
                claim_we    = 1'b1;
                alloc_we    = 1'b1;
                claim_wdata = CW'(count_i);
                alloc_wdata = CW'(held_i);
                rvalid_d = 1'b1; status_d = ST_OK; seqp_d = '0; last_d = 1'b1;
              end else begin
                state_d = S_RD;
              end
            end
            default: begin
              // unused command codes: nothing happens
            end
          endcase
        end
      end

      S_RD: begin
        state_d = S_EXEC;
      end

      S_EXEC: begin
        if (cmd_q == CMD_FREE) begin
          alloc_we      = 1'b1;
          alloc_wdata   = alloc_rd - amt_c;
          avail_d[r_q]  = sat_add(avail_q[r_q], amt_c);
          rvalid_d = 1'b1; status_d = ST_OK; seqp_d = '0; last_d = 1'b1;
          state_d = S_IDLE;
        end else if (cnt_q > avail_q[r_q]) begin
          rvalid_d = 1'b1; status_d = ST_UNAVAIL; seqp_d = '0; last_d = 1'b1;
          state_d = S_IDLE;
        end else if (claim_chk > {1'b0, claim_rd}) begin
          rvalid_d = 1'b1; status_d = ST_EXCEEDS; seqp_d = '0; last_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          // trial grant, then walk
          alloc_we     = 1'b1;
          alloc_wdata  = claim_chk[CW-1:0];
          old_d        = alloc_rd;
          avail_d[r_q] = avail_q[r_q] - cnt_q;
          work_d       = avail_d;
          fin_d        = '0;
          done_d       = '0;
          prog_d       = 1'b0;
          wp_d         = '0;
          state_d      = S_WSEL;
        end
      end

      S_COL: begin
        ram_addr = {wp_q[PW-1:0], r_q};
        state_d  = S_COLACC;
      end

      S_COLACC: begin
        acc_d = sum_c;
        if (wp_q == np_last) begin
          avail_d[r_q] = (cnt_q > sum_c) ? cnt_q - sum_c : '0;
          rvalid_d = 1'b1; status_d = ST_OK; seqp_d = '0; last_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          wp_d    = wp_q + PCW'(1);
          state_d = S_COL;
        end
      end

      S_FA: begin
        ram_addr = {p_q, wr_q};
        state_d  = S_FAACC;
      end

      S_FAACC: begin
        ram_addr      = {p_q, wr_q};
        alloc_we      = 1'b1;
        alloc_wdata   = '0;
        avail_d[wr_q] = sat_add(avail_q[wr_q], alloc_rd);
        if (wr_q == nr_last) begin
          rvalid_d = 1'b1; status_d = ST_OK; seqp_d = '0; last_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          wr_d    = wr_q + RW'(1);
          state_d = S_FA;
        end
      end

      S_WSEL: begin
        if (wp_q == np_c) begin
          // end of a pass: stop when all done or nothing moved
          if ((done_q == np_c) || !prog_q) begin
            state_d = S_WEND;
          end else begin
            wp_d   = '0;
            prog_d = 1'b0;
          end
        end else if (fin_q[wp_q[PW-1:0]]) begin
          wp_d = wp_q + PCW'(1);
        end else begin
          wr_d    = '0;
          state_d = S_WRD;
        end
      end

      S_WRD: begin
        ram_addr = {wp_q[PW-1:0], wr_q};
        state_d  = S_WCHK;
      end

      S_WCHK: begin
        ram_addr = {wp_q[PW-1:0], wr_q};
        if (need_c > work_q[wr_q]) begin
          wp_d    = wp_q + PCW'(1);
          state_d = S_WSEL;
        end else if (wr_q == nr_last) begin
          wr_d    = '0;
          state_d = S_WADDRD;
        end else begin
          wr_d    = wr_q + RW'(1);
          state_d = S_WRD;
        end
      end

      S_WADDRD: begin
        ram_addr = {wp_q[PW-1:0], wr_q};
        state_d  = S_WACC;
      end

      S_WACC: begin
        ram_addr     = {wp_q[PW-1:0], wr_q};
        work_d[wr_q] = sat_add(work_q[wr_q], alloc_rd);
        if (wr_q == nr_last) begin
          fin_d[wp_q[PW-1:0]]       = 1'b1;
          order_d[done_q[PW-1:0]]   = wp_q[PW-1:0];
          done_d                    = done_q + PCW'(1);
          prog_d                    = 1'b1;
          wp_d                      = wp_q + PCW'(1);
          state_d                   = S_WSEL;
        end else begin
          wr_d    = wr_q + RW'(1);
          state_d = S_WADDRD;
        end
      end

      S_WEND: begin
        if (done_q != np_c) begin
          if (cmd_q == CMD_REQUEST) begin
            // undo the trial grant
            alloc_we     = 1'b1;
            alloc_wdata  = old_q;
            avail_d[r_q] = avail_q[r_q] + cnt_q;
          end
          rvalid_d = 1'b1; status_d = ST_UNSAFE; seqp_d = '0; last_d = 1'b1;
          state_d = S_IDLE;
        end else if (cmd_q == CMD_REQUEST) begin
          rvalid_d = 1'b1; status_d = ST_OK; seqp_d = '0; last_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          wp_d    = '0;
          state_d = S_SEQ;
        end
      end

      S_SEQ: begin
        rvalid_d = 1'b1;
        status_d = ST_OK;
        seqp_d   = ProcW'(order_q[wp_q[PW-1:0]]);
        last_d   = (wp_q == np_last);
        wp_d     = wp_q + PCW'(1);
        if (wp_q == np_last) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      act_proc_q <= ActProcW'(8);
      act_res_q  <= ActResW'(4);
      fin_q      <= '0;
      rvalid_q   <= 1'b0;
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        avail_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      fin_q    <= fin_d;
      rvalid_q <= rvalid_d;
      avail_q  <= avail_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ACT_PROC: act_proc_q <= cfg_data_i;
          REG_ACT_RES:  act_res_q  <= cfg_data_i[ActResW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    p_q      <= p_d;
    r_q      <= r_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    old_q    <= old_d;
    wp_q     <= wp_d;
    wr_q     <= wr_d;
    done_q   <= done_d;
    prog_q   <= prog_d;
    work_q   <= work_d;
    order_q  <= order_d;
    status_q <= status_d;
    seqp_q   <= seqp_d;
    last_q   <= last_d;
  end

  assign cfg_ready_o        = 1'b1;
  assign result_valid_o     = rvalid_q;
  assign status_o           = status_q;
  assign sequence_process_o = seqp_q;
  assign last_o             = last_q;

  `BSA_ASSERT_IMP(a_notlast_in_seq, rvalid_q && !last_q, state_q == S_SEQ, "non-final result outside sequence output")
  `BSA_ASSERT_NXT(a_seq_continues, rvalid_q && !last_q, rvalid_q, "safe sequence broken off early")
  `BSA_ASSERT_IMP(a_walk_count, state_q == S_WEND, $countones(fin_q) == done_q, "finished mask and count disagree")
  `BSA_ASSERT_IMP(a_seq_full, state_q == S_SEQ, (done_q == np_c) && ($countones(fin_q) == done_q), "sequence output from incomplete walk")

endmodule
